// ----- hdl/grid_occupancy_bitmap_unit_assert.svh -----
// Assertion macros for the bitmap unit; used by the controller module.
// Both macros sample on i_clk and are disabled while i_rst_n is low.
`ifndef GRID_OCCUPANCY_BITMAP_UNIT_ASSERT_SVH
`define GRID_OCCUPANCY_BITMAP_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define GOB_ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define GOB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define GOB_ASSERT_IMPLIES(lbl, ante, cons, msg)
`define GOB_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ----- hdl/gob_pkg.sv -----
`timescale 1ns / 1ps

package gob_pkg;

    // Store geometry
    localparam int MAX_CELLS = 4096;
    localparam int IDX_W     = $clog2(MAX_CELLS);
    localparam int WORD_BITS = 64;
    localparam int BIT_SEL_W = $clog2(WORD_BITS);
    localparam int DEPTH     = MAX_CELLS / WORD_BITS;
    localparam int ADDR_W    = $clog2(DEPTH);
    localparam int LIMIT_W   = $clog2(MAX_CELLS + 1);

    // Field widths
    localparam int DIM_W     = 7;
    localparam int COORD_W   = 6;
    localparam int PROD_W    = 2 * DIM_W;
    // Largest cell index: (63 + 126) * 127 + 63 + 126 fits in 15 bits
    localparam int K_W       = 15;

    // Configuration port
    localparam int CFG_IDX_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 8'd1;
    localparam logic [DIM_W-1:0]     DIM_RESET       = 7'd64;

    typedef enum logic [1:0] {
        MODE_TEST  = 2'd0,
        MODE_WRITE = 2'd1,
        MODE_RECT  = 2'd2,
        MODE_CLEAR = 2'd3
    } t_mode;

    // Controller -> datapath
    typedef struct packed {
        logic load;       // latch item, compute row base
        logic clr_start;  // restart clear sweep
        logic clr_step;   // zero one word, advance sweep
        logic rd_en;      // read word of current cell
        logic cell_wr;    // modify phase of current cell
        logic advance;    // step to next rectangle cell
    } t_dp_cmd;

    // Datapath -> controller
    typedef struct packed {
        logic  cfg_hit;    // register write this cycle
        logic  clr_last;   // sweep at last word
        logic  cell_last;  // last rectangle cell
        logic  in_empty;   // offered rectangle has no cells
        t_mode mode;       // latched item mode
    } t_dp_status;

endpackage

// ----- hdl/gob_datapath.sv -----
`timescale 1ns / 1ps

module gob_datapath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    input  logic [gob_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [gob_pkg::DIM_W-1:0]     i_cfg_data,
    input  logic [1:0]                    i_mode,
    input  logic [gob_pkg::COORD_W-1:0]   i_cell_x,
    input  logic [gob_pkg::COORD_W-1:0]   i_cell_y,
    input  logic [gob_pkg::DIM_W-1:0]     i_rect_width,
    input  logic [gob_pkg::DIM_W-1:0]     i_rect_height,
    input  logic                          i_bit_value,
    input  gob_pkg::t_dp_cmd              i_cmd,
    output gob_pkg::t_dp_status           o_status,
    output logic                          o_bit_is_set,
    output logic                          o_range_error
);
    import gob_pkg::*;

    // Configuration and derived limit
    logic [DIM_W-1:0]   r_grid_width;
    logic [DIM_W-1:0]   r_grid_height;
    logic [LIMIT_W-1:0] r_limit;
    logic [LIMIT_W-1:0] n_limit;
    logic [PROD_W-1:0]  area;
    logic               cfg_w_hit;
    logic               cfg_h_hit;

    // Item and walk state
    t_mode              r_mode;
    logic [DIM_W-1:0]   r_rw;
    logic [DIM_W-1:0]   r_rh;
    logic               r_bit_value;
    logic [K_W-1:0]     r_base;
    logic [K_W-1:0]     n_base;
    logic [DIM_W-1:0]   r_i;
    logic [DIM_W-1:0]   r_j;
    logic               r_hit;
    logic               r_err;
    logic [K_W-1:0]     cell_k;
    logic               in_range;
    logic               row_end;

    // Store
    logic [WORD_BITS-1:0] r_mem [DEPTH];
    logic [WORD_BITS-1:0] r_rdata;
    logic [ADDR_W-1:0]    r_clr_addr;
    logic [ADDR_W-1:0]    cell_addr;
    logic [BIT_SEL_W-1:0] cell_bit;
    logic                 mem_we;
    logic [ADDR_W-1:0]    mem_waddr;
    logic [WORD_BITS-1:0] mem_wdata;
    logic [WORD_BITS-1:0] merged;

    // Register decode
    assign cfg_w_hit = i_cfg_valid && (i_cfg_index == CFG_GRID_WIDTH);
    assign cfg_h_hit = i_cfg_valid && (i_cfg_index == CFG_GRID_HEIGHT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_width  <= DIM_RESET;
            r_grid_height <= DIM_RESET;
            r_limit       <= LIMIT_W'(MAX_CELLS);
        end else begin
            if (cfg_w_hit) r_grid_width <= i_cfg_data;
            if (cfg_h_hit) r_grid_height <= i_cfg_data;
            r_limit <= n_limit;
        end
    end

    // Limit = min(width * height, MAX_CELLS)
    always_comb begin
        area = PROD_W'(r_grid_width) * PROD_W'(r_grid_height);
        if (area > PROD_W'(MAX_CELLS)) n_limit = LIMIT_W'(MAX_CELLS);
        else n_limit = area[LIMIT_W-1:0];
    end

    // Current cell index and its word / bit
    assign cell_k    = r_base + K_W'(r_j);
    assign in_range  = cell_k < K_W'(r_limit);
    assign cell_addr = cell_k[IDX_W-1:BIT_SEL_W];
    assign cell_bit  = cell_k[BIT_SEL_W-1:0];
    assign row_end   = (DIM_W'(r_j + 1'b1) == r_rw);
    assign n_base    = K_W'(i_cell_y) * K_W'(r_grid_width) + K_W'(i_cell_x);

    // Item latch and rectangle walk
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode      <= t_mode'(i_mode);
            r_rw        <= i_rect_width;
            r_rh        <= i_rect_height;
            r_bit_value <= i_bit_value;
            r_base      <= n_base;
            r_i         <= '0;
            r_j         <= '0;
            r_hit       <= 1'b0;
            r_err       <= 1'b0;
        end else begin
            if (i_cmd.cell_wr) begin
                if (!in_range) r_err <= 1'b1;
                else if (r_mode == MODE_TEST) r_hit <= r_rdata[cell_bit];
            end
            if (i_cmd.advance) begin
                if (row_end) begin
                    r_j    <= '0;
                    r_i    <= DIM_W'(r_i + 1'b1);
                    r_base <= r_base + K_W'(r_grid_width);
                end else begin
                    r_j <= DIM_W'(r_j + 1'b1);
                end
            end
        end
    end

    // Clear sweep address
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clr_start) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clr_step) begin
            r_clr_addr <= ADDR_W'(r_clr_addr + 1'b1);
        end
    end

    // Write port: clear sweep or cell update
    always_comb begin
        merged = r_rdata;
        merged[cell_bit] = (r_mode == MODE_WRITE) ? r_bit_value : 1'b1;
        mem_we    = i_cmd.clr_step
                  || (i_cmd.cell_wr && in_range && (r_mode != MODE_TEST));
        mem_waddr = i_cmd.clr_step ? r_clr_addr : cell_addr;
        mem_wdata = i_cmd.clr_step ? '0 : merged;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_waddr] <= mem_wdata;
        if (i_cmd.rd_en) r_rdata <= r_mem[cell_addr];
    end

    // Status back to the controller
    always_comb begin
        o_status.cfg_hit   = cfg_w_hit || cfg_h_hit;
        o_status.clr_last  = (r_clr_addr == ADDR_W'(DEPTH - 1));
        o_status.cell_last = row_end && (DIM_W'(r_i + 1'b1) == r_rh);
        o_status.in_empty  = (i_rect_width == '0) || (i_rect_height == '0);
        o_status.mode      = r_mode;
    end

    assign o_bit_is_set  = r_hit;
    assign o_range_error = r_err;

endmodule

// ----- hdl/gob_ctrl.sv -----
`timescale 1ns / 1ps
`include "grid_occupancy_bitmap_unit_assert.svh"

module gob_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    input  logic [1:0]          i_mode,
    input  gob_pkg::t_dp_status i_status,
    output logic                busy,
    output logic                o_result_valid,
    output gob_pkg::t_dp_cmd    o_cmd
);
    import gob_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_CLEAR = 5'b00010,
        S_READ  = 5'b00100,
        S_WRITE = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_item;   // clear sweep belongs to an item and reports
    logic   n_item;

    // Register writes hold off new items for that cycle
    assign busy           = (r_state != S_IDLE) || i_status.cfg_hit;
    assign o_result_valid = (r_state == S_DONE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_item  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_item  <= n_item;
        end
    end

    // Next state and datapath commands
    always_comb begin
        n_state = r_state;
        n_item  = r_item;
        o_cmd   = '0;
        if (i_status.cfg_hit) begin
            // geometry change wipes the store
            o_cmd.clr_start = 1'b1;
            n_state         = S_CLEAR;
            n_item          = 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        o_cmd.load = 1'b1;
                        unique case (t_mode'(i_mode))
                            MODE_TEST, MODE_WRITE: n_state = S_READ;
                            MODE_RECT: n_state = i_status.in_empty ? S_DONE : S_READ;
                            MODE_CLEAR: begin
                                o_cmd.clr_start = 1'b1;
                                n_state         = S_CLEAR;
                                n_item          = 1'b1;
                            end
                            default: n_state = S_DONE;
                        endcase
                    end
                end
                S_CLEAR: begin
                    o_cmd.clr_step = 1'b1;
                    if (i_status.clr_last) n_state = r_item ? S_DONE : S_IDLE;
                end
                S_READ: begin
                    o_cmd.rd_en = 1'b1;
                    n_state     = S_WRITE;
                end
                S_WRITE: begin
                    o_cmd.cell_wr = 1'b1;
                    if (i_status.mode == MODE_RECT && !i_status.cell_last) begin
                        o_cmd.advance = 1'b1;
                        n_state       = S_READ;
                    end else begin
                        n_state = S_DONE;
                    end
                end
                S_DONE: begin
                    n_state = S_IDLE;
                end
                default: begin
                    n_state = S_IDLE;
                end
            endcase
        end
    end

    // Checks
    `GOB_ASSERT_NEXT(a_accept_leaves_idle, start && !busy, r_state != S_IDLE, "accepted item left controller idle")
    `GOB_ASSERT_NEXT(a_read_then_write, r_state == S_READ && !i_status.cfg_hit, r_state == S_WRITE, "read not followed by modify phase")
    `GOB_ASSERT_NEXT(a_item_clear_reports, r_state == S_CLEAR && r_item && i_status.clr_last && !i_status.cfg_hit, o_result_valid, "clear-all item gave no result")
    `GOB_ASSERT_IMPLIES(a_walk_only_rect, o_cmd.advance, i_status.mode == MODE_RECT, "cell walk advanced outside rectangle fill")

endmodule

// ----- hdl/grid_occupancy_bitmap_unit.sv -----
// Grid occupancy bitmap: one bit per cell of a width x height grid, cell
// (x, y) at linear index y*width + x, held as 64 words of 64 bits.
// Command channel: an item is taken when start is high and busy is low.
// Modes: test cell, write cell, set rectangle (rows wrap through the
// linear index), clear all. Each item gives one result, shown for exactly
// one cycle with o_result_valid; the receiver cannot hold it off.
// Per item: test or write cell reads the word, tests or modifies it,
// then shows the result; set rectangle reads and modifies each cell in
// turn, then shows the result (at once when empty); clear all sweeps
// every word first. One store port: one read-modify-write per cell.
// Configuration: write channel i_cfg_valid / o_cfg_ready, always ready.
// Index 0 grid width, index 1 grid height; either write clears the store
// with a sweep of every word, during which busy is high. Other indexes are
// ignored. Write only while the block is idle.
// Reset (synchronous, i_rst_n low): geometry 64 x 64, then a clear sweep
// of every word with busy high before the first item is taken.
`timescale 1ns / 1ps

module grid_occupancy_bitmap_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [1:0]                    i_mode,
    input  logic [gob_pkg::COORD_W-1:0]   i_cell_x,
    input  logic [gob_pkg::COORD_W-1:0]   i_cell_y,
    input  logic [gob_pkg::DIM_W-1:0]     i_rect_width,
    input  logic [gob_pkg::DIM_W-1:0]     i_rect_height,
    input  logic                          i_bit_value,
    output logic                          o_result_valid,
    output logic                          o_bit_is_set,
    output logic                          o_range_error,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [gob_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [gob_pkg::DIM_W-1:0]     i_cfg_data
);
    import gob_pkg::*;

    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;

    // Register writes are never held off
    assign o_cfg_ready = 1'b1;

    gob_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_mode        (i_mode),
        .i_cell_x      (i_cell_x),
        .i_cell_y      (i_cell_y),
        .i_rect_width  (i_rect_width),
        .i_rect_height (i_rect_height),
        .i_bit_value   (i_bit_value),
        .i_cmd         (dp_cmd),
        .o_status      (dp_status),
        .o_bit_is_set  (o_bit_is_set),
        .o_range_error (o_range_error)
    );

    gob_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .i_mode         (i_mode),
        .i_status       (dp_status),
        .busy           (busy),
        .o_result_valid (o_result_valid),
        .o_cmd          (dp_cmd)
    );

endmodule
